FILE: hw/rtl/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg: shared types for the line rasteriser
// Holds the command and status groups that pass between the controller and
// the datapath.
// ----------------------------------------------------------------------------
package brl_pkg;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture a new line and prepare the walk
		logic emit;   // write the current pixel out and advance one step
	} brl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic at_end; // the current pixel is the final one of the line
	} brl_sts_t;

endpackage

FILE: hw/rtl/brl_if.sv
// ----------------------------------------------------------------------------
// brl_if: channel interfaces of the line rasteriser
// A segment channel carries two endpoints; a pixel channel carries one
// pixel coordinate and the end-of-line mark.
// ----------------------------------------------------------------------------
interface brl_segment_if #(
	parameter int COORD_BITS = 6
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;

	modport source (output valid, output start_x, output start_y,
		output end_x, output end_y, input ready);
	modport sink (input valid, input start_x, input start_y,
		input end_x, input end_y, output ready);
endinterface

interface brl_pixel_if #(
	parameter int COORD_BITS = 6
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  last;

	modport source (output valid, output pixel_x, output pixel_y,
		output last, input ready);
	modport sink (input valid, input pixel_x, input pixel_y,
		input last, output ready);
endinterface

FILE: hw/rtl/brl_ctrl.sv
// ----------------------------------------------------------------------------
// brl_ctrl: line rasteriser controller
// Two-state machine that takes a segment when idle, then steps the datapath
// once per free output slot until the final pixel has been issued.
// ----------------------------------------------------------------------------
module brl_ctrl
	import brl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output brl_cmd_t cmd,
	input  brl_sts_t sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic slot_free;

	// Handshake and command decode.
	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign cmd.load  = in_valid && in_ready;
	assign cmd.emit  = (state_q == ST_WALK) && slot_free;
	assign out_valid = out_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (cmd.emit && sts.at_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/brl_dpath.sv
// ----------------------------------------------------------------------------
// brl_dpath: line rasteriser datapath
// Works out the walk set-up from the endpoints, holds the walk position and
// error term, and keeps the output pixel register.
// ----------------------------------------------------------------------------
module brl_dpath
	import brl_pkg::*;
#(
	parameter int COORD_BITS = 6
) (
	input  logic                  clk,
	input  brl_cmd_t              cmd,
	output brl_sts_t              sts,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last
);

	localparam int N  = COORD_BITS;
	localparam int EB = COORD_BITS + 3;

	logic [N:0]   dx, dy, ndx, ndy;
	logic [N-1:0] adx, ady;
	logic         steep;
	logic [N-1:0] a_maj, a_min, b_maj, b_min;
	logic [N-1:0] lo_maj, lo_min, hi_maj, hi_min;
	logic [N-1:0] dmin_raw;

	logic         steep_q, up_q;
	logic [N-1:0] major_q, minor_q, end_q, dmaj_q, dmin_q;
	logic signed [EB-1:0] err_q;
	logic signed [EB-1:0] err_add, err_twice, dmaj_ext;
	logic         take_step;

	logic [N-1:0] pixel_x_q, pixel_y_q;
	logic         last_q;

	// Absolute deltas and the steepness decision.
	assign dx    = {1'b0, end_x} - {1'b0, start_x};
	assign dy    = {1'b0, end_y} - {1'b0, start_y};
	assign ndx   = -dx;
	assign ndy   = -dy;
	assign adx   = dx[N] ? ndx[N-1:0] : dx[N-1:0];
	assign ady   = dy[N] ? ndy[N-1:0] : dy[N-1:0];
	assign steep = ady > adx;

	// Axis swap for steep lines, then order the ends along the major axis.
	always_comb begin
		a_maj = steep ? start_y : start_x;
		a_min = steep ? start_x : start_y;
		b_maj = steep ? end_y : end_x;
		b_min = steep ? end_x : end_y;
		if (a_maj > b_maj) begin
			lo_maj = b_maj;
			lo_min = b_min;
			hi_maj = a_maj;
			hi_min = a_min;
		end else begin
			lo_maj = a_maj;
			lo_min = a_min;
			hi_maj = b_maj;
			hi_min = b_min;
		end
		dmin_raw = (hi_min > lo_min) ? (hi_min - lo_min) : (lo_min - hi_min);
	end

	// Error update for one step along the major axis.
	assign dmaj_ext  = signed'({3'b000, dmaj_q});
	assign err_add   = err_q + signed'({3'b000, dmin_q});
	assign err_twice = err_add <<< 1;
	assign take_step = err_twice >= dmaj_ext;

	assign sts.at_end = (major_q == end_q);

	// Walk registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			steep_q <= steep;
			major_q <= lo_maj;
			minor_q <= lo_min;
			end_q   <= hi_maj;
			dmaj_q  <= hi_maj - lo_maj;
			dmin_q  <= dmin_raw;
			up_q    <= lo_min < hi_min;
			err_q   <= '0;
		end else if (cmd.emit) begin
			major_q <= major_q + 1'b1;
			if (take_step) begin
				minor_q <= up_q ? minor_q + 1'b1 : minor_q - 1'b1;
				err_q   <= err_add - dmaj_ext;
			end else begin
				err_q <= err_add;
			end
		end
	end

	// Output pixel register; axes are swapped back for steep lines.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_x_q <= steep_q ? minor_q : major_q;
			pixel_y_q <= steep_q ? major_q : minor_q;
			last_q    <= sts.at_end;
		end
	end

	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign last    = last_q;

endmodule

FILE: hw/rtl/bresenham_line_raster.sv
// After its segment transaction the controller enters the walk state; the first pixel
// of the line is then registered in the output pixel register. A line of n pixels
// (n = major delta + 1) leaves the walk step loop one pixel per cycle unless stalled.
// A stalled pixel output holds the walk; the next segment is taken once the last pixel
// has been issued, while that pixel may still wait in the output register.
// Reset (arst_n, asynchronous) returns the controller to idle and clears output valid.
// ----------------------------------------------------------------------------
// bresenham_line_raster: Bresenham line rasteriser
// Takes one segment per transaction and issues its pixels in order, marking the
// final one.
// ----------------------------------------------------------------------------
module bresenham_line_raster
	import brl_pkg::*;
#(
	parameter int COORD_BITS = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	brl_segment_if.sink   segment,
	brl_pixel_if.source   pixel
);

	brl_cmd_t cmd;
	brl_sts_t sts;

	// Controller.
	brl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (segment.valid),
		.in_ready  (segment.ready),
		.out_valid (pixel.valid),
		.out_ready (pixel.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath.
	brl_dpath #(
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk     (clk),
		.cmd     (cmd),
		.sts     (sts),
		.start_x (segment.start_x),
		.start_y (segment.start_y),
		.end_x   (segment.end_x),
		.end_y   (segment.end_y),
		.pixel_x (pixel.pixel_x),
		.pixel_y (pixel.pixel_y),
		.last    (pixel.last)
	);

endmodule

FILE: test/bresenham_line_raster_tb.sv
// ----------------------------------------------------------------------------
// bresenham_line_raster_tb: self-checking bench for the line rasteriser
// Sends segments over the segment channel and checks every pixel transaction
// against a behavioural rasteriser kept in the bench. A short table of
// directed segments comes first, then randomly shaped segments, with random
// idle bursts on both channels except in the closing stretch of the run.
// ----------------------------------------------------------------------------
module bresenham_line_raster_tb;

	localparam int COORD_BITS = 6;
	localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
	localparam int N_DIRECTED = 21;
	localparam int N_RANDOM   = 460;
	localparam int N_CALM     = 60;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pixel_t;

	// One directed segment; single-pixel rows carry their pixel written out.
	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		logic   typed;
		pixel_t typed_px;
	} segment_row_t;

	logic clk;
	logic arst_n;

	brl_segment_if #(.COORD_BITS(COORD_BITS)) segment_ch ();
	brl_pixel_if   #(.COORD_BITS(COORD_BITS)) pixel_ch ();

	bresenham_line_raster #(
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.segment (segment_ch),
		.pixel   (pixel_ch)
	);

	pixel_t expected_pixels[$];
	pixel_t want_px;
	bit     failed;
	bit     calm;
	int     idle_pct;

	segment_row_t directed_rows [N_DIRECTED] = '{
		'{0,  0,  0,  0,  1'b1, '{0,  0,  1'b1}},
		'{63, 63, 63, 63, 1'b1, '{63, 63, 1'b1}},
		'{42, 21, 42, 21, 1'b1, '{42, 21, 1'b1}},
		'{21, 42, 21, 42, 1'b1, '{21, 42, 1'b1}},
		'{0,  0,  63, 0,  1'b0, '0},
		'{63, 0,  0,  0,  1'b0, '0},
		'{0,  0,  0,  63, 1'b0, '0},
		'{0,  63, 0,  0,  1'b0, '0},
		'{0,  0,  63, 63, 1'b0, '0},
		'{63, 63, 0,  0,  1'b0, '0},
		'{0,  63, 63, 0,  1'b0, '0},
		'{63, 0,  0,  63, 1'b0, '0},
		'{5,  10, 20, 15, 1'b0, '0},
		'{20, 15, 5,  10, 1'b0, '0},
		'{10, 5,  15, 20, 1'b0, '0},
		'{15, 20, 10, 5,  1'b0, '0},
		'{3,  40, 50, 2,  1'b0, '0},
		'{30, 30, 31, 33, 1'b0, '0},
		'{0,  0,  1,  0,  1'b0, '0},
		'{0,  0,  1,  1,  1'b0, '0},
		'{62, 1,  2,  61, 1'b0, '0}
	};

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic coord_t clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return coord_t'(COORD_MAX);
		return coord_t'(v);
	endfunction

	// Walks the segment along its major axis and queues every pixel it sets.
	function automatic void rasterise_line(input coord_t ax, input coord_t ay,
		input coord_t bx, input coord_t by);
		int     x0, y0, x1, y1, t;
		int     dmaj, dmin, minor, step, err;
		bit     steep;
		pixel_t px;
		x0 = ax;
		y0 = ay;
		x1 = bx;
		y1 = by;
		steep = magnitude(y1 - y0) > magnitude(x1 - x0);
		if (steep) begin
			t = x0; x0 = y0; y0 = t;
			t = x1; x1 = y1; y1 = t;
		end
		if (x0 > x1) begin
			t = x0; x0 = x1; x1 = t;
			t = y0; y0 = y1; y1 = t;
		end
		dmaj  = x1 - x0;
		dmin  = magnitude(y1 - y0);
		minor = y0;
		step  = (y0 < y1) ? 1 : -1;
		err   = 0;
		for (int major = x0; major <= x1; major++) begin
			px.x    = coord_t'(steep ? minor : major);
			px.y    = coord_t'(steep ? major : minor);
			px.last = (major == x1);
			expected_pixels.push_back(px);
			err += dmin;
			if (2 * err >= dmaj) begin
				minor += step;
				err   -= dmaj;
			end
		end
	endfunction

	// Offers one segment, possibly after an idle burst, and waits for the transaction.
	task automatic send_segment(input coord_t sx, input coord_t sy,
		input coord_t ex, input coord_t ey);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			segment_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		segment_ch.valid   <= 1'b1;
		segment_ch.start_x <= sx;
		segment_ch.start_y <= sy;
		segment_ch.end_x   <= ex;
		segment_ch.end_y   <= ey;
		do
			@(posedge clk);
		while (!segment_ch.ready);
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// The idle rate changes now and then, so that some stretches run without gaps.
	initial begin
		idle_pct = 0;
		forever begin
			repeat (150) @(negedge clk);
			if (calm)
				idle_pct = 0;
			else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
			end
		end
	end

	// Pixel receiver: ready drops for random bursts at the current idle rate.
	initial begin : pixel_sink
		int hold;
		hold = 0;
		pixel_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0 && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
				hold = $urandom_range(1, 6);
			pixel_ch.ready <= (hold == 0);
			if (hold != 0)
				hold--;
		end
	end

	// Each pixel transaction is compared with the oldest expected pixel.
	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel x=%0d y=%0d last=%0b",
					pixel_ch.pixel_x, pixel_ch.pixel_y, pixel_ch.last);
				failed = 1'b1;
			end else begin
				want_px = expected_pixels.pop_front();
				if (pixel_ch.pixel_x !== want_px.x) begin
					$error("pixel_x: expected %0d, actual %0d", want_px.x, pixel_ch.pixel_x);
					failed = 1'b1;
				end
				if (pixel_ch.pixel_y !== want_px.y) begin
					$error("pixel_y: expected %0d, actual %0d", want_px.y, pixel_ch.pixel_y);
					failed = 1'b1;
				end
				if (pixel_ch.last !== want_px.last) begin
					$error("last: expected %0b, actual %0b", want_px.last, pixel_ch.last);
					failed = 1'b1;
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then random segments.
	initial begin : stimulus
		int sx, sy, ex, ey, len, room_x, room_y;
		bit dir_x, dir_y;
		failed = 1'b0;
		calm   = 1'b0;
		arst_n = 1'b0;
		segment_ch.valid   = 1'b0;
		segment_ch.start_x = '0;
		segment_ch.start_y = '0;
		segment_ch.end_x   = '0;
		segment_ch.end_y   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_segment(directed_rows[i].sx, directed_rows[i].sy,
				directed_rows[i].ex, directed_rows[i].ey);
			if (directed_rows[i].typed)
				expected_pixels.push_back(directed_rows[i].typed_px);
			else
				rasterise_line(directed_rows[i].sx, directed_rows[i].sy,
					directed_rows[i].ex, directed_rows[i].ey);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - N_CALM)
				calm = 1'b1;
			sx = $urandom_range(0, COORD_MAX);
			sy = $urandom_range(0, COORD_MAX);
			ex = $urandom_range(0, COORD_MAX);
			ey = $urandom_range(0, COORD_MAX);
			case ($urandom_range(0, 9))
				// Short segments keep the run quick and exercise every octant.
				3, 4: begin
					ex = clamp_coord(sx + $urandom_range(0, 10) - 5);
					ey = clamp_coord(sy + $urandom_range(0, 10) - 5);
				end
				5: ey = sy;
				6: ex = sx;
				// Exact diagonals, where both deltas are equal.
				7: begin
					dir_x  = $urandom_range(0, 1);
					dir_y  = $urandom_range(0, 1);
					room_x = dir_x ? COORD_MAX - sx : sx;
					room_y = dir_y ? COORD_MAX - sy : sy;
					len    = $urandom_range(0, COORD_MAX);
					if (len > room_x)
						len = room_x;
					if (len > room_y)
						len = room_y;
					ex = dir_x ? sx + len : sx - len;
					ey = dir_y ? sy + len : sy - len;
				end
				8: begin
					ex = sx;
					ey = sy;
				end
				// Endpoints pushed to the edges of the coordinate range.
				9: begin
					sx = $urandom_range(0, 1) ? COORD_MAX : sx;
					sy = $urandom_range(0, 1) ? 0 : sy;
					ex = $urandom_range(0, 1) ? 0 : ex;
					ey = $urandom_range(0, 1) ? COORD_MAX : ey;
				end
				default: ;
			endcase
			send_segment(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
			rasterise_line(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
		end
		segment_ch.valid <= 1'b0;

		// Drain the outstanding pixels, then watch for strays a little longer.
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (COORD_MAX + 16) @(posedge clk);

		if (!failed)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/brl_pkg.sv
hw/rtl/brl_if.sv
hw/rtl/brl_ctrl.sv
hw/rtl/brl_dpath.sv
hw/rtl/bresenham_line_raster.sv
test/bresenham_line_raster_tb.sv
